FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property while out of reset
`define BIQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("biquad assertion failed");

// check a property at every edge, reset included
`define BIQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("biquad assertion failed");

`else

`define BIQ_ASSERT(lbl, clk, rstn, prop)
`define BIQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/biq_pkg.sv
// ---------------------------------------------------------------------------
// biq_pkg
// Widths, types and codes shared by the biquad filter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package biq_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 18;
  localparam int COEF_FRAC_BITS = 14;
  localparam int STATE_BITS     = 24;

  // digit-serial multiplier: coefficient digits, MSB digit first
  localparam int DIGIT_BITS  = 6;
  localparam int COEF_DIGITS = COEF_BITS / DIGIT_BITS;
  localparam int DIG_BITS    = $clog2(COEF_DIGITS);

  localparam int PP_BITS   = STATE_BITS + DIGIT_BITS + 1;
  localparam int PROD_BITS = STATE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int SHR_BITS  = ACC_BITS - COEF_FRAC_BITS;
  localparam int WSUM_BITS = SHR_BITS + 1;

  localparam int TERM_BITS    = 2;
  localparam int FB_TERMS     = 2;
  localparam int FF_TERMS     = 3;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [PP_BITS-1:0]     pp_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  localparam acc_t ROUND_INIT = acc_t'(1) <<< (COEF_FRAC_BITS - 1);

  localparam coef_t B0_RESET = coef_t'(16384);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_FLUSH,
    ST_W,
    ST_FF,
    ST_FF_FLUSH,
    ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    MSEL_D1,
    MSEL_D2,
    MSEL_W
  } msel_t;

  typedef enum logic [2:0] {
    CSEL_B0,
    CSEL_B1,
    CSEL_B2,
    CSEL_A1,
    CSEL_A2
  } csel_t;

  typedef struct packed {
    logic  clr;
    logic  load;
    logic  step;
    logic  flush;
    msel_t msel;
    csel_t csel;
  } mac_ctrl_t;

  typedef struct packed {
    mac_ctrl_t mac;
    logic      w_en;
    logic      commit;
  } seq_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/biq_in_if.sv
// ---------------------------------------------------------------------------
// biq_in_if
// Sample channel: valid/ready handshake carrying one input word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface biq_in_if;
  logic             valid;
  logic             ready;
  biq_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/biq_out_if.sv
// ---------------------------------------------------------------------------
// biq_out_if
// Result channel: valid/ready handshake carrying one filtered word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface biq_out_if;
  logic             valid;
  logic             ready;
  biq_pkg::sample_t filtered;
  logic             state_replaced;

  modport source (output valid, output filtered, output state_replaced, input ready);
  modport sink   (input valid, input filtered, input state_replaced, output ready);
endinterface

`default_nettype wire

FILE: rtl/biq_dsmac.sv
// ---------------------------------------------------------------------------
// biq_dsmac
// Digit-serial multiply-accumulate: coefficient shifted out one digit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module biq_dsmac (
  input  logic                clk,
  input  biq_pkg::mac_ctrl_t  ctrl,
  input  biq_pkg::state_t     mcand,
  input  biq_pkg::coef_t      coef,
  output biq_pkg::acc_t       acc
);

  biq_pkg::coef_t dsr_r, dsr_nxt;
  biq_pkg::prod_t prod_r, prod_nxt;
  biq_pkg::acc_t  acc_r, acc_nxt;

  logic [biq_pkg::DIGIT_BITS-1:0] digit_raw;
  logic signed [biq_pkg::DIGIT_BITS:0] digit_s;
  biq_pkg::pp_t pp;
  biq_pkg::prod_t pp_ext;
  biq_pkg::acc_t  prod_ext;

  // top digit is signed and comes straight from the coefficient on load
  always_comb begin
    if (ctrl.load) begin
      digit_raw = coef[biq_pkg::COEF_BITS-1 -: biq_pkg::DIGIT_BITS];
      digit_s   = {digit_raw[biq_pkg::DIGIT_BITS-1], digit_raw};
    end else begin
      digit_raw = dsr_r[biq_pkg::COEF_BITS-1 -: biq_pkg::DIGIT_BITS];
      digit_s   = {1'b0, digit_raw};
    end
  end

  assign pp       = mcand * digit_s;
  assign pp_ext   = {{(biq_pkg::PROD_BITS - biq_pkg::PP_BITS){pp[biq_pkg::PP_BITS-1]}}, pp};
  assign prod_ext = {{(biq_pkg::ACC_BITS - biq_pkg::PROD_BITS){prod_r[biq_pkg::PROD_BITS-1]}},
                     prod_r};

  always_comb begin
    dsr_nxt  = dsr_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (ctrl.clr) begin
      prod_nxt = '0;
      acc_nxt  = biq_pkg::ROUND_INIT;
    end else if (ctrl.load) begin
      // retire the previous product, open a new one
      dsr_nxt  = coef <<< biq_pkg::DIGIT_BITS;
      prod_nxt = pp_ext;
      acc_nxt  = acc_r + prod_ext;
    end else if (ctrl.step) begin
      dsr_nxt  = dsr_r <<< biq_pkg::DIGIT_BITS;
      prod_nxt = (prod_r <<< biq_pkg::DIGIT_BITS) + pp_ext;
    end else if (ctrl.flush) begin
      prod_nxt = '0;
      acc_nxt  = acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    dsr_r  <= dsr_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

FILE: rtl/biq_seq.sv
// ---------------------------------------------------------------------------
// biq_seq
// Sequencer: walks the feedback and feed-forward terms digit by digit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module biq_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  output logic              in_ready,
  output biq_pkg::seq_ctl_t ctl
);

  localparam logic [biq_pkg::DIG_BITS-1:0] LAST_DIG =
    biq_pkg::DIG_BITS'(biq_pkg::COEF_DIGITS - 1);
  localparam logic [biq_pkg::TERM_BITS-1:0] FB_LAST =
    biq_pkg::TERM_BITS'(biq_pkg::FB_TERMS - 1);
  localparam logic [biq_pkg::TERM_BITS-1:0] FF_LAST =
    biq_pkg::TERM_BITS'(biq_pkg::FF_TERMS - 1);

  biq_pkg::seq_state_t state_r, state_nxt;
  logic [biq_pkg::TERM_BITS-1:0] term_r, term_nxt;
  logic [biq_pkg::DIG_BITS-1:0]  dig_r, dig_nxt;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= biq_pkg::ST_IDLE;
      term_r  <= '0;
      dig_r   <= '0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      dig_r   <= dig_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    dig_nxt   = dig_r;
    in_ready  = 1'b0;
    ctl       = '0;
    case (state_r)
      biq_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.mac.clr = 1'b1;
        term_nxt    = '0;
        dig_nxt     = '0;
        if (in_fire) begin
          state_nxt = biq_pkg::ST_FB;
        end
      end
      biq_pkg::ST_FB: begin
        ctl.mac.load = (dig_r == '0);
        ctl.mac.step = (dig_r != '0);
        ctl.mac.msel = (term_r == '0) ? biq_pkg::MSEL_D1 : biq_pkg::MSEL_D2;
        ctl.mac.csel = (term_r == '0) ? biq_pkg::CSEL_A1 : biq_pkg::CSEL_A2;
        if (dig_r == LAST_DIG) begin
          dig_nxt = '0;
          if (term_r == FB_LAST) begin
            state_nxt = biq_pkg::ST_FB_FLUSH;
          end else begin
            term_nxt = term_r + 1'b1;
          end
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      biq_pkg::ST_FB_FLUSH: begin
        ctl.mac.flush = 1'b1;
        term_nxt      = '0;
        state_nxt     = biq_pkg::ST_W;
      end
      biq_pkg::ST_W: begin
        ctl.w_en    = 1'b1;
        ctl.mac.clr = 1'b1;
        state_nxt   = biq_pkg::ST_FF;
      end
      biq_pkg::ST_FF: begin
        ctl.mac.load = (dig_r == '0);
        ctl.mac.step = (dig_r != '0);
        case (term_r)
          2'd0: begin
            ctl.mac.msel = biq_pkg::MSEL_W;
            ctl.mac.csel = biq_pkg::CSEL_B0;
          end
          2'd1: begin
            ctl.mac.msel = biq_pkg::MSEL_D1;
            ctl.mac.csel = biq_pkg::CSEL_B1;
          end
          default: begin
            ctl.mac.msel = biq_pkg::MSEL_D2;
            ctl.mac.csel = biq_pkg::CSEL_B2;
          end
        endcase
        if (dig_r == LAST_DIG) begin
          dig_nxt = '0;
          if (term_r == FF_LAST) begin
            state_nxt = biq_pkg::ST_FF_FLUSH;
          end else begin
            term_nxt = term_r + 1'b1;
          end
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      biq_pkg::ST_FF_FLUSH: begin
        ctl.mac.flush = 1'b1;
        term_nxt      = '0;
        state_nxt     = biq_pkg::ST_OUT;
      end
      biq_pkg::ST_OUT: begin
        // hold the sum until the output register is free
        if (out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = biq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = biq_pkg::ST_IDLE;
      end
    endcase
  end

  `BIQ_ASSERT(a_accept_starts_fb, clk, rst_n, in_fire |=> state_r == biq_pkg::ST_FB)
  `BIQ_ASSERT(a_load_step_excl, clk, rst_n, !(ctl.mac.load && ctl.mac.step))
  `BIQ_ASSERT(a_w_then_ff, clk, rst_n, state_r == biq_pkg::ST_W |=> state_r == biq_pkg::ST_FF && term_r == '0 && dig_r == '0)

endmodule

`default_nettype wire

FILE: rtl/biquad_lowpass_filter.sv
// Per sample: accept the sample word, multiply the two feedback terms digit
//   by digit, flush, write the feedback result w, multiply the three
//   feed-forward terms, flush, then commit once the output register is free.
//   The single digit-serial multiplier serves all terms, one sample at a time.
// Reset (rst_n low, synchronous): coefficients to b0 = 1.0, others zero,
//   both delay words to zero, no result pending.
// ---------------------------------------------------------------------------
// biquad_lowpass_filter
// Direct form II biquad with digit-serial coefficient multiplication.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module biquad_lowpass_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  biq_in_if.sink                                in_ch,
  biq_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [biq_pkg::COEF_BITS-1:0]         cfg_data
);

  // Coefficient registers, signed Q4.14
  biq_pkg::coef_t b0_r, b1_r, b2_r, a1_r, a2_r;

  // Filter state: w of the last two samples
  biq_pkg::state_t d1_r, d2_r;

  // Per-sample working registers
  biq_pkg::sample_t sample_r;
  biq_pkg::state_t  w_r;
  logic             rep_r;

  // Output register: parts the result side from the input side
  logic             out_valid_r;
  biq_pkg::sample_t out_filtered_r;
  logic             out_rep_r;

  biq_pkg::seq_ctl_t ctl;
  biq_pkg::state_t   mcand;
  biq_pkg::coef_t    coef;
  biq_pkg::acc_t     acc;

  logic in_ready;
  logic in_fire;
  logic out_free;

  biq_pkg::state_t                       x_ext;
  logic signed [biq_pkg::SHR_BITS-1:0]   acc_shr;
  logic signed [biq_pkg::WSUM_BITS-1:0]  w_full;
  logic                                  w_fits;
  biq_pkg::state_t                       w_nxt;
  logic                                  y_fits;
  biq_pkg::sample_t                      y_sat;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered       = out_filtered_r;
  assign out_ch.state_replaced = out_rep_r;

  // -------------------------------------------------------------------------
  // Configuration writes; an index past the last register is dropped
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= biq_pkg::B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        biq_pkg::REG_B0: b0_r <= cfg_data;
        biq_pkg::REG_B1: b1_r <= cfg_data;
        biq_pkg::REG_B2: b2_r <= cfg_data;
        biq_pkg::REG_A1: a1_r <= cfg_data;
        biq_pkg::REG_A2: a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer and digit-serial MAC
  // -------------------------------------------------------------------------
  biq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Multiplicand and coefficient for the term in progress
  always_comb begin
    case (ctl.mac.msel)
      biq_pkg::MSEL_D1: mcand = d1_r;
      biq_pkg::MSEL_D2: mcand = d2_r;
      biq_pkg::MSEL_W:  mcand = w_r;
      default:          mcand = d1_r;
    endcase
    case (ctl.mac.csel)
      biq_pkg::CSEL_B0: coef = b0_r;
      biq_pkg::CSEL_B1: coef = b1_r;
      biq_pkg::CSEL_B2: coef = b2_r;
      biq_pkg::CSEL_A1: coef = a1_r;
      biq_pkg::CSEL_A2: coef = a2_r;
      default:          coef = b0_r;
    endcase
  end

  biq_dsmac u_mac (
    .clk   (clk),
    .ctrl  (ctl.mac),
    .mcand (mcand),
    .coef  (coef),
    .acc   (acc)
  );

  // -------------------------------------------------------------------------
  // Feedback result: w = x - round(fb). The accumulator was preloaded with
  // half an LSB, so dropping the fraction bits gives round half up.
  // -------------------------------------------------------------------------
  assign x_ext   = {{(biq_pkg::STATE_BITS - biq_pkg::SAMPLE_BITS)
                     {sample_r[biq_pkg::SAMPLE_BITS-1]}}, sample_r};
  assign acc_shr = acc[biq_pkg::ACC_BITS-1:biq_pkg::COEF_FRAC_BITS];
  assign w_full  = {{(biq_pkg::WSUM_BITS - biq_pkg::SAMPLE_BITS)
                     {sample_r[biq_pkg::SAMPLE_BITS-1]}}, sample_r}
                 - {acc_shr[biq_pkg::SHR_BITS-1], acc_shr};

  // w must fit the state word; otherwise fall back to the raw sample
  assign w_fits = (&w_full[biq_pkg::WSUM_BITS-1:biq_pkg::STATE_BITS-1])
               || !(|w_full[biq_pkg::WSUM_BITS-1:biq_pkg::STATE_BITS-1]);
  assign w_nxt  = w_fits ? w_full[biq_pkg::STATE_BITS-1:0] : x_ext;

  // -------------------------------------------------------------------------
  // Feed-forward result, saturated to the sample range (same accumulator)
  // -------------------------------------------------------------------------
  assign y_fits = (&acc_shr[biq_pkg::SHR_BITS-1:biq_pkg::SAMPLE_BITS-1])
               || !(|acc_shr[biq_pkg::SHR_BITS-1:biq_pkg::SAMPLE_BITS-1]);

  always_comb begin
    if (y_fits) begin
      y_sat = acc_shr[biq_pkg::SAMPLE_BITS-1:0];
    end else if (acc_shr[biq_pkg::SHR_BITS-1]) begin
      y_sat = {1'b1, {(biq_pkg::SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(biq_pkg::SAMPLE_BITS-1){1'b1}}};
    end
  end

  // -------------------------------------------------------------------------
  // Working registers (payload, no reset)
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_ch.sample;
    end
    if (ctl.w_en) begin
      w_r   <= w_nxt;
      rep_r <= !w_fits;
    end
    if (ctl.commit) begin
      out_filtered_r <= y_sat;
      out_rep_r      <= rep_r;
    end
  end

  // -------------------------------------------------------------------------
  // Delay line and output valid: advance both only when the result commits
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r        <= '0;
      d2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        d2_r <= d1_r;
        d1_r <= w_r;
      end
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `BIQ_ASSERT(a_delay_shift, clk, rst_n, ctl.commit |=> d2_r == $past(d1_r))
  `BIQ_ASSERT(a_replaced_takes_sample, clk, rst_n, ctl.commit && rep_r |=> d1_r == $past(x_ext))
  `BIQ_ASSERT(a_commit_sets_valid, clk, rst_n, ctl.commit |=> out_valid_r)

endmodule

`default_nettype wire

FILE: sim/biq_filter_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biq_filter_check
// Watches the sample, result and coefficient ports of the biquad, predicts
// every filtered word from its own copy of the delay line and coefficients,
// and compares each result word with the oldest prediction.
// ---------------------------------------------------------------------------

module biq_filter_check (
  input  logic                              clk,
  input  logic                              rst_n,
  biq_in_if                                 in_ch,
  biq_out_if                                out_ch,
  input  logic                              cfg_we,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [biq_pkg::COEF_BITS-1:0]     cfg_data,
  output int                                fail_count,
  output int                                words_due,
  output int                                words_checked,
  output int                                replaced_count,
  output int                                clipped_count
);
  import biq_pkg::*;

  typedef struct packed {
    sample_t filtered;
    logic    state_replaced;
  } filt_word_t;

  localparam longint HALF_LSB = longint'(1) <<< (COEF_FRAC_BITS - 1);
  localparam longint STATE_HI = (longint'(1) <<< (STATE_BITS - 1)) - 1;
  localparam longint STATE_LO = -STATE_HI - 1;
  localparam longint OUT_HI   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_LO   = -OUT_HI - 1;

  coef_t      gain_w, gain_d1, gain_d2, fb_d1, fb_d2;
  state_t     w_d1, w_d2;
  filt_word_t filt_due_q[$];
  filt_word_t want;

  // round half up, then drop the fraction bits
  function automatic longint round_q(input longint acc);
    return (acc + HALF_LSB) >>> COEF_FRAC_BITS;
  endfunction

  // one step of the direct form II section; advances the delay line
  function automatic filt_word_t filter_step(input sample_t x);
    longint     w, y;
    filt_word_t r;
    w = longint'(x) - round_q(longint'(w_d1) * longint'(fb_d1)
                              + longint'(w_d2) * longint'(fb_d2));
    r.state_replaced = (w > STATE_HI) || (w < STATE_LO);
    if (r.state_replaced) begin
      w = longint'(x);
      replaced_count++;
    end
    y = round_q(w * longint'(gain_w) + longint'(w_d1) * longint'(gain_d1)
                + longint'(w_d2) * longint'(gain_d2));
    if (y > OUT_HI || y < OUT_LO) begin
      y = (y > OUT_HI) ? OUT_HI : OUT_LO;
      clipped_count++;
    end
    r.filtered = sample_t'(y);
    w_d2 = w_d1;
    w_d1 = state_t'(w);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_w  = B0_RESET;
      gain_d1 = '0;
      gain_d2 = '0;
      fb_d1   = '0;
      fb_d2   = '0;
      w_d1    = '0;
      w_d2    = '0;
      filt_due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_B0:  gain_w  = coef_t'(cfg_data);
          REG_B1:  gain_d1 = coef_t'(cfg_data);
          REG_B2:  gain_d2 = coef_t'(cfg_data);
          REG_A1:  fb_d1   = coef_t'(cfg_data);
          REG_A2:  fb_d2   = coef_t'(cfg_data);
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready)
        filt_due_q.push_back(filter_step(in_ch.sample));

      if (out_ch.valid && out_ch.ready) begin
        if (filt_due_q.size() == 0) begin
          $error("unexpected result word: filtered %0d state_replaced %0b",
                 out_ch.filtered, out_ch.state_replaced);
          fail_count++;
        end else begin
          want = filt_due_q.pop_front();
          words_checked++;
          if (out_ch.filtered !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, out_ch.filtered);
            fail_count++;
          end
          if (out_ch.state_replaced !== want.state_replaced) begin
            $error("state_replaced: expected %0b, got %0b",
                   want.state_replaced, out_ch.state_replaced);
            fail_count++;
          end
        end
      end
    end
    words_due <= filt_due_q.size();
  end

endmodule

FILE: sim/biquad_lowpass_filter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biquad_lowpass_filter_tb
// Drives sample words through the biquad under a series of coefficient
// settings, from pass-through and rounding corners to random stable and
// unstable sections, with bursty input and a stalling result sink. A checker
// beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------

module biquad_lowpass_filter_tb;
  import biq_pkg::*;

  typedef enum int {
    SINK_FREE,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_t;

  typedef enum int {
    SET_LOWPASS,
    SET_WILD,
    SET_EDGE
  } coef_kind_t;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 108;
  localparam int SQUEEZE_WORDS = 8;
  localparam int LONG_HOLD     = 300;
  // extra wait after the last result word comes back, as a margin
  localparam int SETTLE_CYCLES = 24;

  // index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  localparam coef_t   COEF_MAX   = coef_t'(131071);
  localparam coef_t   COEF_MIN   = coef_t'(-131072);
  localparam coef_t   COEF_ZERO  = coef_t'(0);
  localparam coef_t   COEF_HALF  = coef_t'(8192);
  localparam sample_t SAMPLE_MAX = sample_t'(16'h7fff);
  localparam sample_t SAMPLE_MIN = sample_t'(16'h8000);

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COEF_BITS-1:0]    cfg_data;
  logic                    hold_request;
  sink_mode_t              sink_mode;

  int fail_count, words_due, words_checked, replaced_count, clipped_count;
  int settings_used;

  biq_in_if  in_ch ();
  biq_out_if out_ch ();

  biquad_lowpass_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  biq_filter_check filter_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .words_due      (words_due),
    .words_checked  (words_checked),
    .replaced_count (replaced_count),
    .clipped_count  (clipped_count)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result sink. A long hold-off is armed by hold_request and counted here;
  // otherwise ready follows the current sink mode. Rearm once the request
  // has dropped.
  initial begin : result_sink
    int unsigned tick;
    int          hold_left;
    bit          armed;
    tick      = 0;
    hold_left = 0;
    armed     = 1'b1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_request && armed) begin
        armed     = 1'b0;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (!hold_request)
          armed = 1'b1;
        case (sink_mode)
          SINK_FREE:    out_ch.ready <= 1'b1;
          SINK_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          // stall for most of each repeating pattern period, drifting across the block's phases
          SINK_PATTERN: out_ch.ready <= ((tick % 53) >= 30);
          default:      out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Offer one sample word and hold it until the block takes it.
  task automatic push_sample(input sample_t s);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every predicted word to come back, then let the
  // pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five coefficients back to back; optionally hit the spare
  // index first with data that would matter if it were not dropped.
  task automatic load_coefs(input bit poke_spare,
                            input coef_t b0, b1, b2, a1, a2);
    reg_idx_t slot [5];
    coef_t    val  [5];
    slot = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
    val  = '{b0, b1, b2, a1, a2};
    if (poke_spare) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SPARE;
      cfg_data  <= COEF_MAX;
      @(posedge clk);
    end
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= slot[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Full-range noise half the time, with small values, rails and silence mixed in.
  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return sample_t'($urandom);
      5, 6:          return sample_t'($urandom_range(0, 511) - 256);
      7:             return SAMPLE_MAX - sample_t'($urandom_range(0, 3));
      8:             return SAMPLE_MIN + sample_t'($urandom_range(0, 3));
      default:       return sample_t'(0);
    endcase
  endfunction

  // Pick a coefficient set: a stable section (poles inside the unit circle,
  // low- or high-pass zeros), raw random bits, or rails and unity values.
  task automatic load_random_setting(input coef_kind_t kind);
    coef_t c [5];
    int    pole2, gain, a1_span;
    case (kind)
      SET_LOWPASS: begin
        pole2   = $urandom_range(1000, 15800);
        gain    = $urandom_range(40, 4000);
        a1_span = 16384 + pole2 - 300;
        c[0] = coef_t'(gain);
        c[1] = coef_t'(($urandom_range(0, 1) != 0) ? 2 * gain : -2 * gain);
        c[2] = coef_t'(gain);
        c[3] = coef_t'(int'($urandom_range(0, 2 * a1_span)) - a1_span);
        c[4] = coef_t'(pole2);
      end
      SET_WILD: begin
        for (int i = 0; i < 5; i++)
          c[i] = coef_t'($urandom);
      end
      default: begin
        for (int i = 0; i < 5; i++) begin
          case ($urandom_range(0, 4))
            0:       c[i] = COEF_MAX;
            1:       c[i] = COEF_MIN;
            2:       c[i] = COEF_ZERO;
            3:       c[i] = B0_RESET;
            default: c[i] = -B0_RESET;
          endcase
        end
      end
    endcase
    load_coefs(1'b0, c[0], c[1], c[2], c[3], c[4]);
  endtask

  // Send a phase of words in bursts. Some bursts hold one level so the
  // section settles towards its DC response. Optionally stall the sink for
  // a long stretch while words keep coming, or drain fully part way through.
  task automatic run_phase(input int n_words, input bit gappy,
                           input bit squeeze, input bit mid_drain);
    int      sent, burst, gap;
    bit      steady, squeezed, drained;
    sample_t level;
    sent     = 0;
    squeezed = 1'b0;
    drained  = 1'b0;
    while (sent < n_words) begin
      if (squeeze && !squeezed && sent >= n_words / 2) begin
        // block the sink and keep offering words until the input backs up
        hold_request <= 1'b1;
        for (int k = 0; k < SQUEEZE_WORDS; k++)
          push_sample(draw_sample());
        hold_request <= 1'b0;
        sent += SQUEEZE_WORDS;
        squeezed = 1'b1;
      end
      if (mid_drain && !drained && sent >= n_words / 3) begin
        settle();
        drained = 1'b1;
      end
      burst  = $urandom_range(1, 12);
      steady = ($urandom_range(0, 3) == 0);
      level  = draw_sample();
      for (int k = 0; k < burst && sent < n_words; k++) begin
        push_sample(steady ? level : draw_sample());
        sent++;
      end
      gap = (gappy && $urandom_range(0, 3) != 0) ? $urandom_range(1, 30) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_B0;
    cfg_data     <= '0;
    hold_request <= 1'b0;
    sink_mode    <= SINK_RANDOM;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    settings_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients give unity gain: rails, zero and minus one pass
    // straight through.
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(sample_t'(0));
    push_sample(sample_t'(-1));
    settle();

    // Largest positive gain: both rails clip on the output.
    load_coefs(1'b0, COEF_MAX, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(sample_t'(3));
    settle();

    // Most negative gain: the rails swap and clip the other way.
    load_coefs(1'b0, COEF_MIN, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);
    settle();

    // Gain of one half puts odd samples exactly on the rounding midpoint.
    load_coefs(1'b0, COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    push_sample(sample_t'(1));
    push_sample(sample_t'(-1));
    push_sample(sample_t'(3));
    push_sample(sample_t'(-3));
    settle();

    // Feedback of minus eight on the first delay grows the state until it
    // leaves its range and the sample is taken instead; the spare index is
    // hit first and must change nothing.
    load_coefs(1'b1, B0_RESET, COEF_MAX, COEF_MIN, COEF_MIN, COEF_ZERO);
    repeat (6) push_sample(SAMPLE_MAX);
    settle();

    // Every register at a rail, second feedback tap included.
    load_coefs(1'b0, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);

    // Random phases: sink mode, coefficient kind and sender idling rotate.
    // Phases with a free sink also send without gaps. Phase two squeezes
    // the pipeline behind a long sink hold-off; phase five drains mid-way.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      sink_mode <= sink_mode_t'(p % 4);
      load_random_setting(coef_kind_t'(p % 3));
      run_phase(PHASE_WORDS, (p % 4) != 0, p == 2, p == 5);
    end

    settle();
    $display("Checked %0d filtered words over %0d coefficient settings, with bursty",
             words_checked, settings_used);
    $display("input, a %0d-cycle sink hold-off, %0d state fallbacks and %0d clipped words.",
             LONG_HOLD, replaced_count, clipped_count);
    if (fail_count == 0 && words_due == 0)
      $display("biquad_lowpass_filter_tb passed");
    else
      $display("biquad_lowpass_filter_tb failed");
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("biquad_lowpass_filter_tb failed");
    $finish;
  end

endmodule
